@@ sv/efba_pkg.sv @@
`timescale 1ns / 1ps

package efba_pkg;

   // Fixed widths of the request and response fields.
   localparam int SIZE_W   = 16;
   localparam int STATUS_W = 3;
   localparam int PORT_OFF_W = 16;

   // Defaults for the top-level parameters.
   localparam int DEFAULT_MAX_BLOCKS  = 16;
   localparam int DEFAULT_OFFSET_BITS = 16;

   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK         = 3'd0,
      STAT_NO_HEAP    = 3'd1,
      STAT_HEAP_FULL  = 3'd2,
      STAT_TABLE_FULL = 3'd3,
      STAT_NOT_FOUND  = 3'd4
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_SCAN = 1'b1
   } state_type;

   // Outcome of comparing one table entry against the pending request.
   typedef struct packed {
      logic hit;
      logic was_free;
   } match_type;

endpackage

@@ sv/exact_fit_block_allocator.sv @@
`timescale 1ns / 1ps

// Channel    Ports                                          Handshake
// request    req_type, req_size, req_offset                 start & !busy
// response   rsp_block_offset, rsp_status                   rsp_valid, one cycle
// config     csr_wdata (heap size)                          csr_we
//
// A request with the heap size at zero is answered in the next cycle and the
// block stays ready. Otherwise the block holds busy while it walks the table
// one entry per cycle through the single read port of the entry memory.
// A hit ends the scan at the first matching entry; a miss ends it once every
// entry below the fill count has been compared, or straight away when the table
// is empty. The response strobe follows.
// Reset is synchronous; the entry memory needs no clearing pass since only
// entries below the fill count are ever read. The receiver cannot stall.

module exact_fit_block_allocator #(
   parameter int MAX_BLOCKS  = efba_pkg::DEFAULT_MAX_BLOCKS,
   parameter int OFFSET_BITS = efba_pkg::DEFAULT_OFFSET_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_type,
   input  logic [efba_pkg::SIZE_W-1:0]     req_size,
   input  logic [efba_pkg::PORT_OFF_W-1:0] req_offset,
   output logic                            rsp_valid,
   output logic [efba_pkg::PORT_OFF_W-1:0] rsp_block_offset,
   output logic [efba_pkg::STATUS_W-1:0]   rsp_status,
   input  logic                            csr_we,
   input  logic [efba_pkg::SIZE_W-1:0]     csr_wdata
);

   import efba_pkg::*;

   // Address width for the entry table, and a counter width that can also
   // hold MAX_BLOCKS itself.
   localparam int AW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   // One table word: start offset, length and free mark.
   localparam int WW = OFFSET_BITS + SIZE_W + 1;
   // Width wide enough to add a length to a start offset before masking.
   localparam int SW = (OFFSET_BITS > SIZE_W) ? OFFSET_BITS : SIZE_W;

   state_type           state_ff, state_in;
   logic [SIZE_W-1:0]   heap_ff;
   logic [CW-1:0]       count_ff, count_in;
   logic [SIZE_W-1:0]   used_ff, used_in;
   logic [OFFSET_BITS-1:0] tail_ff, tail_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [AW-1:0]       cmp_idx_ff, cmp_idx_in;
   logic                pend_ff, pend_in;
   req_kind_type        kind_ff, kind_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [OFFSET_BITS-1:0] off_ff, off_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PORT_OFF_W-1:0] rsp_offset_ff, rsp_offset_in;
   status_type          rsp_status_ff, rsp_status_in;

   logic                rd_en;
   logic                rd_more;
   logic                we;
   logic [AW-1:0]       wa;
   logic [WW-1:0]       wd;
   logic [WW-1:0]       rd_word;
   logic [OFFSET_BITS-1:0] rd_start;
   logic [SIZE_W-1:0]   rd_length;
   logic                rd_free;
   match_type           match;
   logic [SIZE_W:0]     need_total;
   logic                heap_full;
   logic [SW-1:0]       tail_sum;

   efba_mem #(
      .DEPTH (MAX_BLOCKS),
      .WIDTH (WW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (wa),
      .wr_data (wd),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_word)
   );

   assign rd_start  = rd_word[WW-1 -: OFFSET_BITS];
   assign rd_length = rd_word[SIZE_W:1];
   assign rd_free   = rd_word[0];

   // The one compare unit, applied to each entry as it comes out of memory.
   efba_match #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_match (
      .kind       (kind_ff),
      .req_size   (size_ff),
      .req_offset (off_ff),
      .ent_start  (rd_start),
      .ent_length (rd_length),
      .ent_free   (rd_free),
      .result     (match)
   );

   // Append checks: the used total plus the request must fit in the heap.
   assign need_total = {1'b0, used_ff} + {1'b0, size_ff};
   assign heap_full  = need_total > {1'b0, heap_ff};
   assign tail_sum   = SW'(tail_ff) + SW'(size_ff);
   assign rd_more    = idx_ff < count_ff;

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_block_offset = rsp_offset_ff;
   assign rsp_status       = rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      used_in       = used_ff;
      tail_in       = tail_ff;
      idx_in        = idx_ff;
      cmp_idx_in    = cmp_idx_ff;
      pend_in       = 1'b0;
      kind_in       = kind_ff;
      size_in       = size_ff;
      off_in        = off_ff;
      rsp_valid_in  = 1'b0;
      rsp_offset_in = rsp_offset_ff;
      rsp_status_in = rsp_status_ff;
      rd_en         = 1'b0;
      we            = 1'b0;
      wa            = '0;
      wd            = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               kind_in = req_kind_type'(req_type);
               size_in = req_size;
               off_in  = OFFSET_BITS'(req_offset);
               idx_in  = '0;
               if (heap_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_offset_in = '0;
                  rsp_status_in = STAT_NO_HEAP;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            // Issue the next read while the previous entry is compared.
            rd_en = rd_more;
            if (rd_more) begin
               idx_in     = idx_ff + CW'(1);
               pend_in    = 1'b1;
               cmp_idx_in = idx_ff[AW-1:0];
            end

            if (pend_ff && match.hit) begin
               state_in     = S_IDLE;
               pend_in      = 1'b0;
               rsp_valid_in = 1'b1;
               if ((kind_ff == REQ_FREE) && match.was_free) begin
                  // Double free: left as it is and reported.
                  rsp_offset_in = '0;
                  rsp_status_in = STAT_NOT_FOUND;
               end else begin
                  we            = 1'b1;
                  wa            = cmp_idx_ff;
                  wd            = {rd_start, rd_length, (kind_ff == REQ_FREE)};
                  rsp_offset_in = PORT_OFF_W'(rd_start);
                  rsp_status_in = STAT_OK;
               end
            end else if (!pend_ff && !rd_more) begin
               // The whole table was walked without a hit.
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_offset_in = '0;
               if (kind_ff == REQ_FREE) begin
                  rsp_status_in = STAT_NOT_FOUND;
               end else if (heap_full) begin
                  rsp_status_in = STAT_HEAP_FULL;
               end else if (count_ff == CW'(MAX_BLOCKS)) begin
                  rsp_status_in = STAT_TABLE_FULL;
               end else begin
                  // Append a new block at the end of the last one.
                  we            = 1'b1;
                  wa            = count_ff[AW-1:0];
                  wd            = {tail_ff, size_ff, 1'b0};
                  count_in      = count_ff + CW'(1);
                  used_in       = need_total[SIZE_W-1:0];
                  tail_in       = tail_sum[OFFSET_BITS-1:0];
                  rsp_offset_in = PORT_OFF_W'(tail_ff);
                  rsp_status_in = STAT_OK;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         heap_ff      <= '0;
         count_ff     <= '0;
         used_ff      <= '0;
         tail_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         tail_ff      <= tail_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            heap_ff <= csr_wdata;
         end
      end
   end

   // Request fields, scan index and response payload need no reset.
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      kind_ff       <= kind_in;
      size_ff       <= size_in;
      off_ff        <= off_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

@@ sv/efba_mem.sv @@
`timescale 1ns / 1ps

module efba_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 33
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/efba_match.sv @@
`timescale 1ns / 1ps

module efba_match #(
   parameter int OFFSET_BITS = 16
) (
   input  efba_pkg::req_kind_type   kind,
   input  logic [efba_pkg::SIZE_W-1:0] req_size,
   input  logic [OFFSET_BITS-1:0]   req_offset,
   input  logic [OFFSET_BITS-1:0]   ent_start,
   input  logic [efba_pkg::SIZE_W-1:0] ent_length,
   input  logic                     ent_free,
   output efba_pkg::match_type      result
);

   import efba_pkg::*;

   // An allocate looks for a freed block of exactly the requested length;
   // a free looks for the first block starting at the given offset.
   always_comb begin
      result.was_free = ent_free;
      case (kind)
         REQ_ALLOC: result.hit = ent_free && (ent_length == req_size);
         REQ_FREE:  result.hit = (ent_start == req_offset);
         default:   result.hit = 1'b0;
      endcase
   end

endmodule

@@ sim/exact_fit_block_allocator_tb.sv @@
`timescale 1ns / 1ps

module exact_fit_block_allocator_tb;
   import efba_pkg::*;

   // The table depth and offset width match the defaults the block is built with.
   localparam int TABLE_DEPTH = DEFAULT_MAX_BLOCKS;
   localparam int OFF_BITS    = DEFAULT_OFFSET_BITS;

   // A hit or miss scan is bounded by the table depth, and the sender's pauses are
   // bounded too. This limit on cycles with no accepted beat on either channel
   // is far above the slowest correct run.
   localparam int STALL_LIMIT = 2000;

   // The block answers within a scan's length, so this many quiet cycles at
   // the end is enough for any stray response to show up.
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      logic [PORT_OFF_W-1:0] offset;
      status_type            status;
   } alloc_reply_type;

   // Mirror of the block table. Every accepted request beat is applied here
   // in order, and the response it should produce is queued until the block
   // delivers one.
   class heap_ledger;
      logic [SIZE_W-1:0]     heap_size;
      logic [PORT_OFF_W-1:0] blk_start [TABLE_DEPTH];
      logic [SIZE_W-1:0]     blk_len [TABLE_DEPTH];
      bit                    blk_free [TABLE_DEPTH];
      int unsigned           blk_count;
      logic [SIZE_W-1:0]     used_total;
      alloc_reply_type       awaited [$];
      int unsigned           errors;
      int unsigned           replies_seen;

      function new();
         heap_size    = '0;
         blk_count    = 0;
         used_total   = '0;
         errors       = 0;
         replies_seen = 0;
      endfunction

      function alloc_reply_type apply_request(input req_kind_type kind,
                                              input logic [SIZE_W-1:0] size,
                                              input logic [PORT_OFF_W-1:0] offset);
         alloc_reply_type       r;
         logic [PORT_OFF_W-1:0] base;
         r.offset = '0;
         r.status = STAT_OK;
         if (heap_size == 0) begin
            r.status = STAT_NO_HEAP;
            return r;
         end
         if (kind == REQ_ALLOC) begin
            // A freed block of exactly the requested length is reused first.
            for (int i = 0; i < blk_count; i++) begin
               if (blk_free[i] && blk_len[i] == size) begin
                  blk_free[i] = 1'b0;
                  r.offset = blk_start[i];
                  return r;
               end
            end
            if ({1'b0, used_total} + {1'b0, size} > {1'b0, heap_size}) begin
               r.status = STAT_HEAP_FULL;
               return r;
            end
            if (blk_count >= TABLE_DEPTH) begin
               r.status = STAT_TABLE_FULL;
               return r;
            end
            base = (blk_count == 0) ? '0
                 : blk_start[blk_count - 1] + blk_len[blk_count - 1];
            blk_start[blk_count] = base;
            blk_len[blk_count]   = size;
            blk_free[blk_count]  = 1'b0;
            blk_count++;
            used_total = used_total + size;
            r.offset = base;
            return r;
         end
         // Only the first entry with a matching start is considered, so a
         // second free of the same offset is refused.
         for (int i = 0; i < blk_count; i++) begin
            if (blk_start[i] == offset) begin
               if (blk_free[i]) begin
                  r.status = STAT_NOT_FOUND;
                  return r;
               end
               blk_free[i] = 1'b1;
               r.offset = blk_start[i];
               return r;
            end
         end
         r.status = STAT_NOT_FOUND;
         return r;
      endfunction

      function void log_request(input req_kind_type kind,
                                input logic [SIZE_W-1:0] size,
                                input logic [PORT_OFF_W-1:0] offset);
         awaited.push_back(apply_request(kind, size, offset));
      endfunction

      task report(input string msg);
         errors++;
         $display("[%0t] mismatch: %s", $realtime, msg);
      endtask

      task match_response(input logic [PORT_OFF_W-1:0] offset,
                          input logic [STATUS_W-1:0] status);
         alloc_reply_type want;
         replies_seen++;
         if (awaited.size() == 0) begin
            report($sformatf("reply %0d arrived with nothing outstanding (offset %h status %0d)",
                             replies_seen, offset, status));
            return;
         end
         want = awaited.pop_front();
         if (offset !== want.offset)
            report($sformatf("reply %0d block offset %h, expected %h",
                             replies_seen, offset, want.offset));
         if (status !== want.status)
            report($sformatf("reply %0d status %0d, expected %0d (%s)",
                             replies_seen, status, want.status, want.status.name()));
      endtask
   endclass

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  start      = 1'b0;
   logic                  busy;
   logic                  req_type   = 1'b0;
   logic [SIZE_W-1:0]     req_size   = '0;
   logic [PORT_OFF_W-1:0] req_offset = '0;
   logic                  rsp_valid;
   logic [PORT_OFF_W-1:0] rsp_block_offset;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  csr_we     = 1'b0;
   logic [SIZE_W-1:0]     csr_wdata  = '0;

   heap_ledger sb = new();
   int unsigned idle_cycles = 0;

   exact_fit_block_allocator #(
      .MAX_BLOCKS  (TABLE_DEPTH),
      .OFFSET_BITS (OFF_BITS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_size         (req_size),
      .req_offset       (req_offset),
      .rsp_valid        (rsp_valid),
      .rsp_block_offset (rsp_block_offset),
      .rsp_status       (rsp_status),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Response monitor and watchdog. Everything here is sampled at the rising
   // edge, so it sees the values that the edge itself acts on. A response beat
   // lasts one cycle and cannot be held off, so each strobe is one beat.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) sb.match_response(rsp_block_offset, rsp_status);
         if (rsp_valid || (start && !busy)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
               $display("[%0t] no beat moved for %0d cycles", $realtime, idle_cycles);
               $display("** exact_fit_block_allocator: FAILED **");
               $finish;
            end
         end
      end
   end

   // Presents one request beat and returns at the edge that accepts it. The
   // start line is left high, so a caller that sends the next beat at once
   // does not toggle it within the step.
   task send_beat(input req_kind_type kind, input logic [SIZE_W-1:0] size,
                  input logic [PORT_OFF_W-1:0] offset);
      req_type   <= kind;
      req_size   <= size;
      req_offset <= offset;
      start      <= 1'b1;
      do @(posedge clock); while (busy);
      sb.log_request(kind, size, offset);
   endtask

   task pause(input int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Holds the sender back until every outstanding response has come and the
   // block has dropped busy.
   task wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (sb.awaited.size() != 0 || busy);
      repeat (2) @(posedge clock);
   endtask

   // The heap size register is only touched while the block is quiet. The
   // ledger takes the new value at the same edge the block does.
   task write_heap(input logic [SIZE_W-1:0] value);
      wait_drained();
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.heap_size = value;
   endtask

   // Random traffic. Most beats are well formed: allocations that ask for the
   // length of a block already in the table, so reuse gets exercised, and
   // frees that name a start the table really holds. The rest is small and
   // full-range noise. Runs of 40 beats are either back to back or gappy.
   task run_random(input int unsigned count, input bit gaps_on);
      req_kind_type          kind;
      logic [SIZE_W-1:0]     size;
      logic [PORT_OFF_W-1:0] offset;
      int unsigned           roll;
      bit                    dense;
      dense = 1'b0;
      for (int unsigned k = 0; k < count; k++) begin
         if (k % 40 == 0) dense = ($urandom_range(0, 2) == 0);
         kind   = req_kind_type'($urandom_range(0, 1));
         size   = SIZE_W'($urandom());
         offset = PORT_OFF_W'($urandom());
         roll   = $urandom_range(0, 9);
         if (kind == REQ_ALLOC) begin
            if (roll < 5 && sb.blk_count > 0)
               size = sb.blk_len[$urandom_range(0, sb.blk_count - 1)];
            else if (roll < 8)
               size = SIZE_W'($urandom_range(0, 64));
         end else if (roll < 7 && sb.blk_count > 0) begin
            offset = sb.blk_start[$urandom_range(0, sb.blk_count - 1)];
         end
         send_beat(kind, size, offset);
         if (gaps_on && !dense) begin
            if ($urandom_range(0, 59) == 0) wait_drained();
            else if ($urandom_range(0, 3) == 0) pause($urandom_range(1, 6));
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // With no heap created, both request kinds are refused.
      send_beat(REQ_ALLOC, 16'd5, 16'hFFFF);
      send_beat(REQ_FREE, 16'hFFFF, 16'd0);

      // A small heap: a zero-length block at offset zero, two real blocks
      // that fill the heap exactly, then an allocation that cannot fit.
      write_heap(16'd100);
      send_beat(REQ_ALLOC, 16'd0, 16'h0000);
      send_beat(REQ_ALLOC, 16'd40, 16'hFFFF);
      send_beat(REQ_ALLOC, 16'd60, 16'h1234);
      send_beat(REQ_ALLOC, 16'hFFFF, 16'd0);
      // Offset zero is shared by the zero-length block and the next one;
      // only the first is freed, and a second free of it is a double free.
      send_beat(REQ_FREE, 16'hFFFF, 16'd0);
      send_beat(REQ_FREE, 16'd0, 16'd0);
      // The freed zero-length block is reused by a zero-size allocation.
      send_beat(REQ_ALLOC, 16'd0, 16'hFFFF);
      send_beat(REQ_FREE, 16'd7, 16'hFFFF);

      // A full heap lets the table fill up; after that only the table limit
      // can refuse an allocation that fits.
      write_heap(16'hFFFF);
      for (int k = 0; k < TABLE_DEPTH - 3; k++)
         send_beat(REQ_ALLOC, (k == 0) ? 16'd0 : 16'($urandom_range(1, 48)), 16'($urandom()));
      send_beat(REQ_ALLOC, 16'd3000, 16'hAAAA);

      // Random phases under different heap sizes. The table is kept across
      // each change; only the heap-full test and the no-heap check see the new size.
      run_random(300, 1'b1);
      write_heap(16'd0);
      run_random(60, 1'b1);
      write_heap(sb.used_total);
      run_random(250, 1'b1);
      write_heap(16'($urandom_range(1, 65535)));
      run_random(250, 1'b1);
      write_heap(16'hFFFF);
      run_random(115, 1'b1);
      // The closing stretch runs with the sender never idling.
      run_random(150, 1'b0);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("** exact_fit_block_allocator: PASSED **");
      end else begin
         $display("** exact_fit_block_allocator: FAILED **");
      end
      $finish;
   end

endmodule
